// File: rtl/orsrch_pkg.sv
package orsrch_pkg;

  // Device id width and position encoding
  localparam int unsigned ID_BITS = 64;
  localparam int unsigned IDX_W   = $clog2(ID_BITS);
  localparam int unsigned POS_W   = 7;
  localparam int unsigned CNT_W   = 8;

  // Position marker for "no zero branch taken"
  localparam logic [POS_W-1:0] POS_NONE     = 7'd127;
  // Descent position at search start: past the last bit, no descent yet
  localparam logic [POS_W-1:0] DESCENT_INIT = POS_W'(ID_BITS);
  // Last bit slot of a pass and the position just past it
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(ID_BITS - 1);
  localparam logic [POS_W-1:0] POS_END      = POS_W'(ID_BITS);
  localparam logic [CNT_W-1:0] MAX_DEV_RST  = 8'd64;

  typedef enum logic [1:0] {
    CMD_NEW_SEARCH = 2'd0,
    CMD_PASS_START = 2'd1,
    CMD_BIT_PAIR   = 2'd2,
    CMD_ABORT      = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_BIT_OK    = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NO_DEVICE = 3'd2,
    ST_ENDED     = 3'd3,
    ST_ABORTED   = 3'd4,
    ST_LIMIT     = 3'd5
  } status_e;

  typedef struct packed {
    cmd_e command;
    logic presence;
    logic id_bit;
    logic cmpl_bit;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic                 direction_bit;
    logic [ID_BITS-1:0]   rom_id;
    logic                 last_dev;
    logic                 limit_warning;
  } out_item_t;

endpackage

// File: rtl/orsrch_in_reg.sv
module orsrch_in_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  orsrch_pkg::in_item_t  in_data_i,
  input  logic                  advance_i,
  output logic                  valid_o,
  output orsrch_pkg::in_item_t  data_o
);

  logic                 valid_q, valid_d;
  orsrch_pkg::in_item_t data_q;
  logic                 load;

  // Stage takes a new transaction when empty or when its content moves on
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/orsrch_engine.sv
module orsrch_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [orsrch_pkg::CNT_W-1:0]        cfg_data_i,
  input  logic                                fire_i,
  input  orsrch_pkg::in_item_t                item_i,
  output orsrch_pkg::out_item_t               result_o
);

  // Search state
  logic [orsrch_pkg::CNT_W-1:0]   max_dev_q;
  logic [orsrch_pkg::ID_BITS-1:0] prev_id_q, prev_id_d;
  logic [orsrch_pkg::ID_BITS-1:0] cur_id_q, cur_id_d;
  logic [orsrch_pkg::ID_BITS-1:0] saved_id_q, saved_id_d;
  logic [orsrch_pkg::POS_W-1:0]   bit_pos_q, bit_pos_d;
  logic [orsrch_pkg::POS_W-1:0]   last_zero_q, last_zero_d;
  logic [orsrch_pkg::POS_W-1:0]   descent_q, descent_d;
  logic [orsrch_pkg::CNT_W-1:0]   pass_cnt_q, pass_cnt_d;
  logic                           done_q, done_d;
  logic                           active_q, active_d;
  logic                           warn_q, warn_d;

  // Bit slot decision
  logic [orsrch_pkg::IDX_W-1:0]   idx;
  logic                           want;
  logic                           dir;
  logic                           limit_hit;
  logic [orsrch_pkg::POS_W-1:0]   lz_new;
  logic [orsrch_pkg::ID_BITS-1:0] cur_new;

  assign idx       = bit_pos_q[orsrch_pkg::IDX_W-1:0];
  assign limit_hit = pass_cnt_q >= max_dev_q;

  always_comb begin
    if (bit_pos_q == descent_q) begin
      want = 1'b1;
    end else if (bit_pos_q > descent_q) begin
      want = 1'b0;
    end else begin
      want = prev_id_q[idx];
    end
  end

  // Both bits low is a discrepancy: follow the chosen branch
  assign dir     = (!item_i.id_bit && !item_i.cmpl_bit) ? want : item_i.id_bit;
  assign lz_new  = (!item_i.id_bit && !item_i.cmpl_bit && !want) ? bit_pos_q : last_zero_q;
  assign cur_new = cur_id_q | (orsrch_pkg::ID_BITS'(dir) << idx);

  // Next state and result
  always_comb begin
    prev_id_d   = prev_id_q;
    cur_id_d    = cur_id_q;
    saved_id_d  = saved_id_q;
    bit_pos_d   = bit_pos_q;
    last_zero_d = last_zero_q;
    descent_d   = descent_q;
    pass_cnt_d  = pass_cnt_q;
    done_d      = done_q;
    active_d    = active_q;
    warn_d      = warn_q;

    result_o               = '0;
    result_o.status        = orsrch_pkg::ST_BIT_OK;
    result_o.direction_bit = 1'b1;

    unique case (item_i.command)
      orsrch_pkg::CMD_NEW_SEARCH: begin
        cur_id_d    = saved_id_q;
        prev_id_d   = '0;
        bit_pos_d   = '0;
        last_zero_d = orsrch_pkg::POS_NONE;
        descent_d   = orsrch_pkg::DESCENT_INIT;
        pass_cnt_d  = '0;
        done_d      = 1'b0;
        active_d    = 1'b0;
        warn_d      = 1'b0;
      end
      orsrch_pkg::CMD_ABORT: begin
        active_d        = 1'b0;
        done_d          = 1'b1;
        result_o.status = orsrch_pkg::ST_ABORTED;
      end
      orsrch_pkg::CMD_PASS_START: begin
        priority if (done_q) begin
          result_o.status = orsrch_pkg::ST_ENDED;
        end else if (active_q) begin
          // restart of the running pass, not counted again
          cur_id_d  = '0;
          bit_pos_d = '0;
        end else if (limit_hit) begin
          result_o.status = orsrch_pkg::ST_LIMIT;
        end else if (!item_i.presence) begin
          done_d          = 1'b1;
          result_o.status = orsrch_pkg::ST_NO_DEVICE;
        end else begin
          pass_cnt_d = pass_cnt_q + 1'b1;
          prev_id_d  = cur_id_q;
          cur_id_d   = '0;
          bit_pos_d  = '0;
          active_d   = 1'b1;
        end
      end
      orsrch_pkg::CMD_BIT_PAIR: begin
        priority if (!active_q || bit_pos_q >= orsrch_pkg::POS_END) begin
          if (done_q) begin
            result_o.status = orsrch_pkg::ST_ENDED;
          end else begin
            result_o.status = orsrch_pkg::ST_NO_DEVICE;
          end
        end else if (item_i.id_bit && item_i.cmpl_bit) begin
          // nobody answered the slot
          active_d        = 1'b0;
          warn_d          = warn_q | limit_hit;
          result_o.status = orsrch_pkg::ST_NO_DEVICE;
        end else begin
          cur_id_d               = cur_new;
          last_zero_d            = lz_new;
          bit_pos_d              = bit_pos_q + 1'b1;
          result_o.direction_bit = dir;
          if (bit_pos_q == orsrch_pkg::POS_LAST) begin
            // pass complete
            active_d         = 1'b0;
            descent_d        = lz_new;
            result_o.status  = orsrch_pkg::ST_FOUND;
            result_o.rom_id  = cur_new;
            if (lz_new == descent_q || lz_new == orsrch_pkg::POS_NONE) begin
              result_o.last_dev = 1'b1;
              saved_id_d        = '0;
              done_d            = 1'b1;
            end else begin
              saved_id_d = cur_new;
              warn_d     = warn_q | limit_hit;
            end
          end
        end
      end
      default: begin
        result_o.status = orsrch_pkg::ST_BIT_OK;
      end
    endcase

    result_o.limit_warning = warn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dev_q <= orsrch_pkg::MAX_DEV_RST;
    end else if (cfg_we_i) begin
      max_dev_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_id_q   <= '0;
      cur_id_q    <= '0;
      saved_id_q  <= '0;
      bit_pos_q   <= '0;
      last_zero_q <= orsrch_pkg::POS_NONE;
      descent_q   <= orsrch_pkg::DESCENT_INIT;
      pass_cnt_q  <= '0;
      done_q      <= 1'b0;
      active_q    <= 1'b0;
      warn_q      <= 1'b0;
    end else if (fire_i) begin
      prev_id_q   <= prev_id_d;
      cur_id_q    <= cur_id_d;
      saved_id_q  <= saved_id_d;
      bit_pos_q   <= bit_pos_d;
      last_zero_q <= last_zero_d;
      descent_q   <= descent_d;
      pass_cnt_q  <= pass_cnt_d;
      done_q      <= done_d;
      active_q    <= active_d;
      warn_q      <= warn_d;
    end
  end

endmodule

// File: rtl/orsrch_out_reg.sv
module orsrch_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  orsrch_pkg::out_item_t  data_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output orsrch_pkg::out_item_t  out_data_o
);

  logic                  valid_q, valid_d;
  orsrch_pkg::out_item_t data_q;

  // Free when empty or when the waiting transaction is taken this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: rtl/onewire_rom_search_top.sv
// Channel | Signals                               | Direction
// input   | in_valid_i, in_stall_o, in_data_i     | bit slot / command in
// output  | out_valid_o, out_stall_i, out_data_o  | one result per command out
// config  | cfg_we_i, cfg_data_i                  | max_devices write
//
// One transaction per cycle sustained while out_stall_i is low: the decision
// is a single stage between the input register and the result register,
// state updated as it moves on. An accepted command waits in the input
// register, then its result is loaded into the result register and presented.
// Reset leaves a fresh search with max_devices at 64.
// An output stall holds the result register; the input register then fills
// and in_stall_o rises.
module onewire_rom_search_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  orsrch_pkg::in_item_t             in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output orsrch_pkg::out_item_t            out_data_o,
  input  logic                             cfg_we_i,
  input  logic [orsrch_pkg::CNT_W-1:0]     cfg_data_i
);

  logic                  advance;
  logic                  stage_valid;
  logic                  fire;
  orsrch_pkg::in_item_t  stage_item;
  orsrch_pkg::out_item_t result;

  assign fire = stage_valid && advance;

  orsrch_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .data_o     (stage_item)
  );

  orsrch_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (stage_item),
    .result_o   (result)
  );

  orsrch_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .data_i      (result),
    .ready_o     (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
